// ===== rtl/l3d_pkg.sv =====
// Shared types and constants of the 3D color table interpolator.
package l3d_pkg;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUT_SIZE = 1'b0,
    REG_BYPASS   = 1'b1
  } l3d_reg_t;

  // Table size after reset.
  localparam int LUT_SIZE_RST = 17;

  // Queue depths between front and back, and in front of the result port.
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Number of cube corners read per sample.
  localparam int CORNERS = 8;

  // Classification of one beat travelling from front to back.
  typedef struct packed {
    logic load;
    logic byp;
  } l3d_ctrl_t;

endpackage

// ===== rtl/l3d_fifo.sv =====
// Small register-based queue with occupancy count.
module l3d_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic                       empty,
  output logic [W-1:0]               dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];
  assign count   = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/l3d_front.sv =====
// Front end: accepts beats, clamps and scales colors, forms corner addresses.
module l3d_front #(
  parameter int LUT_MAX_SIZE = 17,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_req_type,
  input  logic [$clog2(LUT_MAX_SIZE**3)-1:0]    in_entry_index,
  input  logic [CHANNEL_BITS-1:0]               in_entry_red,
  input  logic [CHANNEL_BITS-1:0]               in_entry_green,
  input  logic [CHANNEL_BITS-1:0]               in_entry_blue,
  input  logic signed [CHANNEL_BITS+1:0]        in_red,
  input  logic signed [CHANNEL_BITS+1:0]        in_green,
  input  logic signed [CHANNEL_BITS+1:0]        in_blue,
  input  logic [$clog2(LUT_MAX_SIZE+1)-1:0]     size_eff,
  input  logic [$clog2(LUT_MAX_SIZE+1)-1:0]     size_m1,
  input  logic [2*$clog2(LUT_MAX_SIZE+1)-1:0]   size_sq,
  input  logic                                  byp,
  output logic                                  q_push,
  input  logic                                  q_full,
  output l3d_pkg::l3d_ctrl_t                    q_ctrl,
  output logic [7:0][$clog2(LUT_MAX_SIZE**3)-1:0] q_addr,
  output logic [2:0][CHANNEL_BITS-1:0]          q_frac,
  output logic [2:0][CHANNEL_BITS-1:0]          q_color
);

  localparam int CB    = CHANNEL_BITS;
  localparam int IW    = CHANNEL_BITS + 2;
  localparam int DEPTH = LUT_MAX_SIZE**3;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(LUT_MAX_SIZE + 1);
  localparam int FW    = CB + 1 + SW;

  logic [2:0][IW-1:0] cin;
  logic               en, accept, load_ok;

  // Stage A: clamped and scaled channels.
  logic               a_vld_r;
  l3d_pkg::l3d_ctrl_t a_ctrl_r;
  logic [AW-1:0]      a_idx_r;
  logic [2:0][CB-1:0] a_color_r, a_color_nxt;
  logic [2:0][FW-1:0] a_f_r, a_f_nxt;

  // Stage B: per-axis address terms for the low and high neighbor.
  logic                    b_vld_r;
  l3d_pkg::l3d_ctrl_t      b_ctrl_r;
  logic [AW-1:0]           b_idx_r;
  logic [2:0][CB-1:0]      b_color_r;
  logic [2:0][CB-1:0]      b_frac_r, b_frac_nxt;
  logic [2:0][1:0][AW-1:0] b_term_r, b_term_nxt;

  assign cin     = {in_blue, in_green, in_red};
  assign en      = !(b_vld_r && q_full);
  assign in_full = !en;
  assign accept  = in_push && en;
  // Loads beyond the table are dropped here.
  assign load_ok = (32'(in_entry_index) < DEPTH);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [CB:0] cl;
      logic [CB-1:0] sat;
      if (cin[k][IW-1]) begin
        cl  = '0;
        sat = '0;
      end else if (|cin[k][IW-2:CB]) begin
        cl  = {1'b1, {CB{1'b0}}};
        sat = '1;
      end else begin
        cl  = {1'b0, cin[k][CB-1:0]};
        sat = cin[k][CB-1:0];
      end
      a_f_nxt[k]     = FW'(cl) * FW'(size_m1);
      a_color_nxt[k] = sat;
    end
    if (!in_req_type) begin
      a_color_nxt = {in_entry_blue, in_entry_green, in_entry_red};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [SW-1:0]   i0, i1;
      logic [SW:0]     i0p;
      logic [2*SW-1:0] scale;
      i0  = SW'(a_f_r[k][FW-1:CB]);
      i0p = {1'b0, i0} + 1'b1;
      i1  = (i0p < {1'b0, size_m1}) ? i0p[SW-1:0] : size_m1;
      if (i0 > size_m1) begin
        i0 = size_m1;
      end
      case (k)
        0:       scale = (2*SW)'(1);
        1:       scale = (2*SW)'(size_eff);
        default: scale = size_sq;
      endcase
      b_term_nxt[k][0] = AW'(32'(i0) * 32'(scale));
      b_term_nxt[k][1] = AW'(32'(i1) * 32'(scale));
      b_frac_nxt[k]    = a_f_r[k][CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= accept && (in_req_type || load_ok);
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctrl_r.load <= !in_req_type;
      a_ctrl_r.byp  <= byp;
      a_idx_r       <= in_entry_index;
      a_color_r     <= a_color_nxt;
      a_f_r         <= a_f_nxt;
      b_ctrl_r      <= a_ctrl_r;
      b_idx_r       <= a_idx_r;
      b_color_r     <= a_color_r;
      b_frac_r      <= b_frac_nxt;
      b_term_r      <= b_term_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      q_addr[c] = b_term_r[0][c % 2] + b_term_r[1][(c / 2) % 2] + b_term_r[2][c / 4];
    end
    if (b_ctrl_r.load) begin
      q_addr[0] = b_idx_r;
    end
  end

  assign q_push  = b_vld_r && !q_full;
  assign q_ctrl  = b_ctrl_r;
  assign q_frac  = b_frac_r;
  assign q_color = b_color_r;

endmodule

// ===== rtl/l3d_mem.sv =====
// Color table storage, replicated so that all eight corners are read together.
module l3d_mem #(
  parameter int DEPTH = 4913,
  parameter int AW    = 13,
  parameter int DW    = 48
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [DW-1:0]       wdata,
  input  logic                re,
  input  logic [7:0][AW-1:0]  raddr,
  output logic [7:0][DW-1:0]  rdata
);

  for (genvar g = 0; g < 4; g++) begin : g_copy
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd0_r, rd1_r;

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (re) begin
        rd0_r <= mem[raddr[2*g]];
        rd1_r <= mem[raddr[2*g+1]];
      end
    end

    assign rdata[2*g]   = rd0_r;
    assign rdata[2*g+1] = rd1_r;
  end

endmodule

// ===== rtl/l3d_back.sv =====
// Back end: table writes, corner reads and the three interpolation stages.
module l3d_back #(
  parameter int LUT_MAX_SIZE = 17,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_empty,
  output logic                                    q_pop,
  input  l3d_pkg::l3d_ctrl_t                      q_ctrl,
  input  logic [7:0][$clog2(LUT_MAX_SIZE**3)-1:0] q_addr,
  input  logic [2:0][CHANNEL_BITS-1:0]            q_frac,
  input  logic [2:0][CHANNEL_BITS-1:0]            q_color,
  input  logic [l3d_pkg::OUT_CNT_W-1:0]           o_cnt,
  output logic                                    o_push,
  output logic [2:0][CHANNEL_BITS-1:0]            o_color
);

  localparam int CB    = CHANNEL_BITS;
  localparam int DEPTH = LUT_MAX_SIZE**3;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [CB-1:0] lerp(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                         input logic [CB-1:0] t);
    logic signed [CB+1:0]     diff;
    logic signed [2*CB+3:0]   acc;
    diff = $signed({2'b00, b}) - $signed({2'b00, a});
    acc  = $signed({4'b0000, a, {CB{1'b0}}}) + diff * $signed({2'b00, t})
         + $signed({{(CB+4){1'b0}}, 1'b1, {(CB-1){1'b0}}});
    return acc[2*CB-1:CB];
  endfunction

  logic                           issue, is_load;
  logic [l3d_pkg::OUT_CNT_W-1:0]  inflight;
  logic [7:0][3*CB-1:0]           rdata;

  logic               v1_r, v2_r, v3_r;
  logic               byp1_r, byp2_r, byp3_r;
  logic [2:0][CB-1:0] frac1_r;
  logic [2:1][CB-1:0] frac2_r;
  logic [CB-1:0]      frac3_r;
  logic [2:0][CB-1:0] col1_r, col2_r, col3_r;
  logic [2:0][3:0][CB-1:0] c2_r, c2_nxt;
  logic [2:0][1:0][CB-1:0] d3_r, d3_nxt;

  assign is_load  = q_ctrl.load;
  assign inflight = l3d_pkg::OUT_CNT_W'(v1_r) + l3d_pkg::OUT_CNT_W'(v2_r)
                  + l3d_pkg::OUT_CNT_W'(v3_r);
  // Samples issue only when the result queue is sure to have room.
  assign issue = !q_empty && (is_load || (o_cnt + inflight < l3d_pkg::OUT_CNT_W'(l3d_pkg::OUT_DEPTH)));
  assign q_pop = issue;

  l3d_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (3*CB)
  ) u_mem (
    .clk   (clk),
    .we    (issue && is_load),
    .waddr (q_addr[0]),
    .wdata (q_color),
    .re    (issue && !is_load),
    .raddr (q_addr),
    .rdata (rdata)
  );

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 4; j++) begin
        c2_nxt[ch][j] = lerp(rdata[2*j][ch*CB +: CB], rdata[2*j+1][ch*CB +: CB], frac1_r[0]);
      end
      for (int bb = 0; bb < 2; bb++) begin
        d3_nxt[ch][bb] = lerp(c2_r[ch][2*bb], c2_r[ch][2*bb+1], frac2_r[1]);
      end
      o_color[ch] = byp3_r ? col3_r[ch] : lerp(d3_r[ch][0], d3_r[ch][1], frac3_r);
    end
  end

  assign o_push = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue && !is_load;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    byp1_r  <= q_ctrl.byp;
    frac1_r <= q_frac;
    col1_r  <= q_color;
    byp2_r  <= byp1_r;
    frac2_r <= frac1_r[2:1];
    col2_r  <= col1_r;
    c2_r    <= c2_nxt;
    byp3_r  <= byp2_r;
    frac3_r <= frac2_r[2];
    col3_r  <= col2_r;
    d3_r    <= d3_nxt;
  end

endmodule

// ===== rtl/lut3d_trilinear_color_map.sv =====
// Top level of the 3D color table with trilinear interpolation.
//
// Input channel: a queue-like push/full port. A beat with in_req_type low
// writes one table entry (in_entry_index, in_entry_*) and gives no result;
// a beat with in_req_type high samples the color in_red/in_green/in_blue.
// Result channel: a queue-like empty/pop port; each sample beat yields one
// result beat on out_red/out_green/out_blue, in input order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Register
// 0 is the grid size per axis, register 1 the bypass flag. cfg_ready is
// always high; write only while the block is idle.
// Throughput is one beat per cycle while no full queue holds the input. A
// sample passes from input acceptance to the result port through two front
// stages, the command queue, the registered table read and three blend stages.
// All eight corners are read together from four copies of the table,
// each with two read ports.
// When the receiver stops popping, the result queue fills, the back end
// stops issuing samples, the command queue fills and full rises.
// Reset empties all queues and restores size 17 and bypass off; the table
// contents are not cleared and must be loaded before they are sampled.
module lut3d_trilinear_color_map #(
  parameter int LUT_MAX_SIZE = 17,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_req_type,
  input  logic [$clog2(LUT_MAX_SIZE**3)-1:0]  in_entry_index,
  input  logic [CHANNEL_BITS-1:0]             in_entry_red,
  input  logic [CHANNEL_BITS-1:0]             in_entry_green,
  input  logic [CHANNEL_BITS-1:0]             in_entry_blue,
  input  logic signed [CHANNEL_BITS+1:0]      in_red,
  input  logic signed [CHANNEL_BITS+1:0]      in_green,
  input  logic signed [CHANNEL_BITS+1:0]      in_blue,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [CHANNEL_BITS-1:0]             out_red,
  output logic [CHANNEL_BITS-1:0]             out_green,
  output logic [CHANNEL_BITS-1:0]             out_blue,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [l3d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [l3d_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CB    = CHANNEL_BITS;
  localparam int AW    = $clog2(LUT_MAX_SIZE**3);
  localparam int SW    = $clog2(LUT_MAX_SIZE + 1);
  localparam int RST_S = (l3d_pkg::LUT_SIZE_RST > LUT_MAX_SIZE) ? LUT_MAX_SIZE
                                                                : l3d_pkg::LUT_SIZE_RST;
  localparam int CTW   = $bits(l3d_pkg::l3d_ctrl_t);
  localparam int QW    = CTW + 8*AW + 6*CB;

  // The grid size is clamped and its derived products formed at write time,
  // so the front end sees settled values.
  logic [SW-1:0]   size_eff_r, size_eff_nxt;
  logic [SW-1:0]   size_m1_r, size_m1_nxt;
  logic [2*SW-1:0] size_sq_r, size_sq_nxt;
  logic            bypass_r, bypass_nxt;

  always_comb begin
    size_eff_nxt = size_eff_r;
    bypass_nxt   = bypass_r;
    if (cfg_valid && cfg_ready) begin
      case (l3d_pkg::l3d_reg_t'(cfg_index))
        l3d_pkg::REG_LUT_SIZE: begin
          if (32'(cfg_data) < 2) begin
            size_eff_nxt = SW'(2);
          end else if (32'(cfg_data) > LUT_MAX_SIZE) begin
            size_eff_nxt = SW'(LUT_MAX_SIZE);
          end else begin
            size_eff_nxt = SW'(cfg_data);
          end
        end
        l3d_pkg::REG_BYPASS: bypass_nxt = cfg_data[0];
        default: ;
      endcase
    end
    size_m1_nxt = size_eff_nxt - 1'b1;
    size_sq_nxt = (2*SW)'(size_eff_nxt) * (2*SW)'(size_eff_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_eff_r <= SW'(RST_S);
      size_m1_r  <= SW'(RST_S - 1);
      size_sq_r  <= (2*SW)'(RST_S * RST_S);
      bypass_r   <= 1'b0;
    end else begin
      size_eff_r <= size_eff_nxt;
      size_m1_r  <= size_m1_nxt;
      size_sq_r  <= size_sq_nxt;
      bypass_r   <= bypass_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // Front end to command queue.
  logic                    f_push, q_full, q_empty, q_pop;
  l3d_pkg::l3d_ctrl_t      f_ctrl, b_ctrl;
  logic [7:0][AW-1:0]      f_addr, b_addr;
  logic [2:0][CB-1:0]      f_frac, f_color, b_frac, b_color;
  logic [QW-1:0]           q_din, q_dout;
  logic [$clog2(l3d_pkg::CMD_DEPTH+1)-1:0] q_cnt;

  l3d_front #(
    .LUT_MAX_SIZE (LUT_MAX_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_red   (in_entry_red),
    .in_entry_green (in_entry_green),
    .in_entry_blue  (in_entry_blue),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .size_eff       (size_eff_r),
    .size_m1        (size_m1_r),
    .size_sq        (size_sq_r),
    .byp            (bypass_r),
    .q_push         (f_push),
    .q_full         (q_full),
    .q_ctrl         (f_ctrl),
    .q_addr         (f_addr),
    .q_frac         (f_frac),
    .q_color        (f_color)
  );

  assign q_din = {f_ctrl, f_addr, f_frac, f_color};
  assign {b_ctrl, b_addr, b_frac, b_color} = q_dout;

  l3d_fifo #(
    .W     (QW),
    .DEPTH (l3d_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .full  (q_full),
    .din   (q_din),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout),
    .count (q_cnt)
  );

  // Back end to result queue.
  logic                          o_push, o_full;
  logic [2:0][CB-1:0]            o_color, r_color;
  logic [l3d_pkg::OUT_CNT_W-1:0] o_cnt;

  l3d_back #(
    .LUT_MAX_SIZE (LUT_MAX_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_ctrl  (b_ctrl),
    .q_addr  (b_addr),
    .q_frac  (b_frac),
    .q_color (b_color),
    .o_cnt   (o_cnt),
    .o_push  (o_push),
    .o_color (o_color)
  );

  l3d_fifo #(
    .W     (3*CB),
    .DEPTH (l3d_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .full  (o_full),
    .din   (o_color),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (r_color),
    .count (o_cnt)
  );

  assign out_red   = r_color[0];
  assign out_green = r_color[1];
  assign out_blue  = r_color[2];

`ifndef SYNTHESIS
  // Credit scheme: a result never arrives at a full result queue.
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full)
    else $error("result beat arrived at a full result queue");

  // The front end only hands a beat over when the command queue has room.
  a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> (q_cnt != ($clog2(l3d_pkg::CMD_DEPTH+1))'(l3d_pkg::CMD_DEPTH)))
    else $error("front end pushed into a full command queue");

  // The back end never issues from an empty command queue.
  a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end issued from an empty command queue");
`endif

endmodule
